// File: rtl/xoshiro256_eight_lane_generator_defines.svh
// Assertion helpers used by the top-level generator.
`ifndef XOSHIRO256_EIGHT_LANE_GENERATOR_DEFINES_SVH
`define XOSHIRO256_EIGHT_LANE_GENERATOR_DEFINES_SVH

// cond seen at one edge implies expr at the next edge
`define XO8_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

// cond implies expr at the same edge
`define XO8_ASSERT_SAME(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

`endif

// File: rtl/xo8_pkg.sv
package xo8_pkg;

    localparam int WORD_W             = 64;
    localparam int WORDS_PER_LANE     = 4;
    localparam int WORD_IDX_W         = 2;
    localparam int LANE_IDX_W         = 3;
    localparam int OUT_FIELDS         = 8;
    localparam int DEFAULT_LANE_COUNT = 8;

    // request payload layout
    localparam int LANE_LSB    = 0;
    localparam int WORD_LSB    = LANE_LSB + LANE_IDX_W;
    localparam int SEED_LSB    = WORD_LSB + WORD_IDX_W;
    localparam int IN_FIELDS_W = SEED_LSB + WORD_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = OUT_FIELDS * WORD_W;

    localparam int ADV_SHIFT = 17;
    localparam int ADV_ROT   = 45;
    localparam int PP_ROT    = 23;
    localparam int SS_ROT    = 7;

    typedef enum logic [1:0] {
        MODE_PLUSPLUS = 2'd0,
        MODE_STARSTAR = 2'd1,
        MODE_PLUS     = 2'd2
    } mode_t;

    typedef enum logic {
        OP_GENERATE = 1'b0,
        OP_LOAD     = 1'b1
    } opcode_t;

    typedef struct packed {
        logic                  gen;
        logic                  load;
        logic [LANE_IDX_W-1:0] lane;
        logic [WORD_IDX_W-1:0] word;
        mode_t                 mode;
    } xo8_ctrl_t;

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] x,
                                                 input int unsigned k);
        return (x << k) | (x >> (WORD_W - k));
    endfunction

endpackage

// File: rtl/xo8_lane.sv
module xo8_lane #(
    parameter int LANE_ID = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  xo8_pkg::xo8_ctrl_t        ctrl,
    input  logic [xo8_pkg::WORD_W-1:0] seed_value,
    output logic [xo8_pkg::WORD_W-1:0] part_a,
    output logic [xo8_pkg::WORD_W-1:0] part_b
);
    import xo8_pkg::*;

    logic [WORD_W-1:0] s_reg  [WORDS_PER_LANE];
    logic [WORD_W-1:0] s_next [WORDS_PER_LANE];
    logic [WORD_W-1:0] part_a_reg;
    logic [WORD_W-1:0] part_a_next;
    logic [WORD_W-1:0] part_b_reg;
    logic              lane_sel;

    assign lane_sel = (32'(ctrl.lane) == LANE_ID);

    always_comb
    begin
        s_next = s_reg;
        if (ctrl.gen)
        begin
            s_next[0] = s_reg[0] ^ s_reg[1] ^ s_reg[3];
            s_next[1] = s_reg[1] ^ s_reg[2] ^ s_reg[0];
            s_next[2] = (s_reg[1] << ADV_SHIFT) ^ s_reg[2] ^ s_reg[0];
            s_next[3] = rotl64(s_reg[1] ^ s_reg[3], ADV_ROT);
        end
        else if (ctrl.load && lane_sel)
        begin
            s_next[ctrl.word] = seed_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < WORDS_PER_LANE; w++)
            begin
                s_reg[w] <= '0;
            end
        end
        else
        begin
            s_reg <= s_next;
        end
    end

    // first half of the scrambler: the wide add (or times five for star-star)
    always_comb
    begin
        case (ctrl.mode)
            MODE_STARSTAR: part_a_next = s_reg[1] + (s_reg[1] << 2);
            default:       part_a_next = s_reg[0] + s_reg[3];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.gen)
        begin
            part_a_reg <= part_a_next;
            part_b_reg <= s_reg[0];
        end
    end

    assign part_a = part_a_reg;
    assign part_b = part_b_reg;

endmodule

// File: rtl/xo8_merge.sv
module xo8_merge #(
    parameter int LANE_COUNT = xo8_pkg::DEFAULT_LANE_COUNT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  xo8_pkg::mode_t                          in_mode,
    input  logic [LANE_COUNT-1:0][xo8_pkg::WORD_W-1:0] part_a,
    input  logic [LANE_COUNT-1:0][xo8_pkg::WORD_W-1:0] part_b,
    output logic                                    in_ready,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [xo8_pkg::OUT_TDATA_W-1:0]         out_data
);
    import xo8_pkg::*;

    logic                                   out_valid_reg;
    logic [OUT_FIELDS-1:0][WORD_W-1:0]      out_data_reg;
    logic [OUT_FIELDS-1:0][WORD_W-1:0]      out_data_next;

    assign in_ready = !out_valid_reg || out_ready;

    for (genvar f = 0; f < OUT_FIELDS; f++)
    begin : g_field
        if (f < LANE_COUNT)
        begin : g_live
            logic [WORD_W-1:0] rot_pp;
            logic [WORD_W-1:0] rot_ss;
            assign rot_pp = rotl64(part_a[f], PP_ROT);
            assign rot_ss = rotl64(part_a[f], SS_ROT);
            always_comb
            begin
                case (in_mode)
                    MODE_PLUSPLUS: out_data_next[f] = rot_pp + part_b[f];
                    MODE_STARSTAR: out_data_next[f] = rot_ss + (rot_ss << 3);
                    default:       out_data_next[f] = part_a[f];
                endcase
            end
        end
        else
        begin : g_idle
            assign out_data_next[f] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/xoshiro256_eight_lane_generator.sv
// Channel   Direction  Handshake                  Payload
// s_*       in         s_tvalid / s_tready        tuser opcode, tdata lane/word/seed
// m_*       out        m_tvalid / m_tready        tdata lane0..lane7 outputs
// cfg_*     in         cfg_valid / cfg_ready      cfg_data output_mode
//
// One request per cycle while s_tready is high; a generate shows its outputs after
// stage 1 (state advance and scrambler add) and stage 2 (rotate and final add).
// Loads complete in the accepting cycle and give no output.
// Reset clears every lane's state and selects plus-plus.
// s_tready drops only while both pipeline stages hold results that m_tready stalls.
`include "xoshiro256_eight_lane_generator_defines.svh"

module xoshiro256_eight_lane_generator #(
    parameter int LANE_COUNT = xo8_pkg::DEFAULT_LANE_COUNT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [xo8_pkg::IN_TDATA_W-1:0]   s_tdata,  // lane_index, word_index, seed_value
    input  logic                             s_tuser,  // opcode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [xo8_pkg::OUT_TDATA_W-1:0]  m_tdata,  // lane0_value .. lane7_value
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_data
);
    import xo8_pkg::*;

    mode_t                             mode_reg;
    logic                              st1_valid_reg;
    mode_t                             st1_mode_reg;
    logic                              st1_ready;
    logic                              gen_fire;
    logic                              load_fire;
    xo8_ctrl_t                         ctrl;
    logic [LANE_COUNT-1:0][WORD_W-1:0] part_a;
    logic [LANE_COUNT-1:0][WORD_W-1:0] part_b;

    assign cfg_ready = 1'b1;
    assign s_tready  = !st1_valid_reg || st1_ready;
    assign gen_fire  = s_tvalid && s_tready && (s_tuser == OP_GENERATE);
    assign load_fire = s_tvalid && s_tready && (s_tuser == OP_LOAD);

    assign ctrl.gen  = gen_fire;
    assign ctrl.load = load_fire;
    assign ctrl.lane = s_tdata[LANE_LSB +: LANE_IDX_W];
    assign ctrl.word = s_tdata[WORD_LSB +: WORD_IDX_W];
    assign ctrl.mode = mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PLUSPLUS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= mode_t'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
        end
        else if (gen_fire)
        begin
            st1_valid_reg <= 1'b1;
        end
        else if (st1_ready)
        begin
            st1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (gen_fire)
        begin
            st1_mode_reg <= mode_reg;
        end
    end

    for (genvar l = 0; l < LANE_COUNT; l++)
    begin : g_lane
        xo8_lane #(
            .LANE_ID (l)
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .seed_value (s_tdata[SEED_LSB +: WORD_W]),
            .part_a     (part_a[l]),
            .part_b     (part_b[l])
        );
    end

    xo8_merge #(
        .LANE_COUNT (LANE_COUNT)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (st1_valid_reg),
        .in_mode   (st1_mode_reg),
        .part_a    (part_a),
        .part_b    (part_b),
        .in_ready  (st1_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    `XO8_ASSERT_NEXT(a_gen_fills_st1, gen_fire, st1_valid_reg, "generate request lost in stage 1")
    `XO8_ASSERT_NEXT(a_load_no_result, load_fire && !st1_valid_reg, !st1_valid_reg, "load request produced a result")
    `XO8_ASSERT_NEXT(a_st1_holds, st1_valid_reg && !st1_ready, st1_valid_reg && $stable(st1_mode_reg), "stalled stage 1 dropped or changed")
    `XO8_ASSERT_SAME(a_no_accept_when_full, st1_valid_reg && m_tvalid && !m_tready, !s_tready, "request accepted with pipeline full")

endmodule
